FILE: design/mre_pkg.sv
package mre_pkg;

   // Field and register widths
   localparam int XLEN                  = 32;
   localparam int REG_COUNT             = 32;
   localparam int REG_IDX_W             = 5;
   localparam int PC_W                  = 9;
   localparam int STEP_W                = 18;
   localparam int LEN_CFG_W             = 9;
   localparam int LINE_W                = 16;
   localparam int MODE_W                = 4;
   localparam int STATUS_W              = 3;
   localparam int PRINT_W               = 2;
   localparam int CSR_INDEX_W           = 1;
   localparam int CSR_DATA_W            = 18;
   localparam int PROGRAM_DEPTH_DEFAULT = 256;

   localparam logic [STEP_W-1:0]    STEP_LIMIT_RESET = STEP_W'(200000);
   localparam logic [REG_IDX_W-1:0] REG_ZERO         = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_A0           = REG_IDX_W'(10);
   localparam logic [REG_IDX_W-1:0] REG_A7           = REG_IDX_W'(17);
   localparam int                   LUI_SHIFT        = 12;

   // Environment call numbers held in a7
   localparam logic [XLEN-1:0] SYS_PRINT_DEC = XLEN'(1);
   localparam logic [XLEN-1:0] SYS_PRINT_HEX = XLEN'(2);
   localparam logic [XLEN-1:0] SYS_EXIT      = XLEN'(10);

   typedef enum logic [MODE_W-1:0] {
      OP_LI    = 4'd0,
      OP_MV    = 4'd1,
      OP_ADDI  = 4'd2,
      OP_ADD   = 4'd3,
      OP_SUB   = 4'd4,
      OP_LUI   = 4'd5,
      OP_J     = 4'd6,
      OP_BEQ   = 4'd7,
      OP_BNE   = 4'd8,
      OP_ECALL = 4'd9,
      OP_NOP   = 4'd10
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_RUNNING    = 3'd0,
      ST_HALTED     = 3'd1,
      ST_STEP_LIMIT = 3'd2,
      ST_BAD_ECALL  = 3'd3,
      ST_BAD_OPCODE = 3'd4,
      ST_STOPPED    = 3'd5
   } status_type;

   typedef enum logic [PRINT_W-1:0] {
      PRINT_NONE = 2'd0,
      PRINT_DEC  = 2'd1,
      PRINT_HEX  = 2'd2
   } print_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_LIMIT     = 1'd0,
      CSR_PROGRAM_LENGTH = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [REG_IDX_W-1:0] src_reg_a;
      logic [REG_IDX_W-1:0] src_reg_b;
      logic signed [XLEN-1:0] immediate;
      logic [PC_W-1:0]      jump_target;
      logic [LINE_W-1:0]    line_number;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]      next_pc;
      logic [STATUS_W-1:0]  status;
      logic [PRINT_W-1:0]   print_kind;
      logic signed [XLEN-1:0] print_value;
      logic [LINE_W-1:0]    fault_line;
   } rsp_type;

endpackage

FILE: design/mre_chan_if.sv
interface mre_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/mini_rv32_integer_executor.sv
// Integer executor for a small RV32I-like subset, one decoded instruction per word.
// req_if carries an instruction word (the one at the current program counter);
// rsp_if returns one word per instruction: next pc, status, print request and
// the fault line. Both use valid/ready; a word moves when both are high.
// csr_we/csr_index/csr_wdata write step_limit (index 0) or program_length
// (index 1); write them only while no instruction is in flight.
// An accepted word is registered into the execute stage; its result is then
// registered into the result register when that stage advances.
// Throughput: one instruction per cycle while results are taken. Operand
// reads go through two copies of the 32-entry register file RAM (one read
// port each) in the accept cycle; the execute stage then adds, compares and
// writes back, bypassing the last write-back into the following instruction.
// Reset clears pc, step count, stopped flag, all register valid bits (every
// register reads zero), the pipeline and the result register, and reloads
// the configuration defaults. No clearing pass runs.
// When the receiver stalls, the result register holds, the execute stage
// holds one more instruction, and req_if.ready drops until the result leaves.
module mini_rv32_integer_executor
   import mre_pkg::*;
#(
   parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   mre_chan_if.sink               req_if,
   mre_chan_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Width wide enough for both the pc and the program depth
   localparam int DEPTH_W = $clog2(PROGRAM_DEPTH + 1);
   localparam int LEN_W   = (DEPTH_W > PC_W) ? DEPTH_W : PC_W;
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(PROGRAM_DEPTH);

   // Configuration
   logic [STEP_W-1:0]    step_limit_ff;
   logic [LEN_CFG_W-1:0] program_length_ff;

   // Architectural state outside the RAM
   logic [PC_W-1:0]      pc_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 stopped_ff;
   logic [REG_COUNT-1:0] reg_valid_ff;
   logic [XLEN-1:0]      a0_ff;
   logic [XLEN-1:0]      a7_ff;

   // Last write-back, bypassed into the next instruction's operands
   logic                 fwd_en_ff;
   logic [REG_IDX_W-1:0] fwd_addr_ff;
   logic [XLEN-1:0]      fwd_data_ff;

   // Execute stage and result register
   logic    s1_valid_ff;
   req_type s1_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic           accept;
   logic           advance;
   logic [XLEN-1:0] ram_a_q;
   logic [XLEN-1:0] ram_b_q;
   logic [XLEN-1:0] opa;
   logic [XLEN-1:0] opb;
   logic [LEN_W-1:0] eff_len;
   logic             pc_past_end;
   logic             step_over;

   logic [PC_W-1:0]  next_pc_in;
   status_type       status_in;
   print_type        kind_in;
   logic [XLEN-1:0]  pval_in;
   logic [LINE_W-1:0] fline_in;
   logic             wr_req;
   logic             wr_en;
   logic [XLEN-1:0]  wr_data;
   logic             stop_set;
   logic             pc_load;
   logic             step_inc;
   rsp_type          rsp_in;

   // Handshake: take a new word whenever the execute stage is free or moving on
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || advance;
   assign accept        = req_if.valid && req_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // Register file: two copies, same writes, one read port each
   mre_ram #(
      .WIDTH (XLEN),
      .DEPTH (REG_COUNT)
   ) u_rf_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.dest_reg),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_if.payload.src_reg_a),
      .rd_data (ram_a_q)
   );

   mre_ram #(
      .WIDTH (XLEN),
      .DEPTH (REG_COUNT)
   ) u_rf_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.dest_reg),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_if.payload.src_reg_b),
      .rd_data (ram_b_q)
   );

   // Operand select: x0 and never-written registers read zero; bypass the last
   // write-back, which may land in the same edge as this word's RAM read.
   always_comb begin
      opa = reg_valid_ff[s1_ff.src_reg_a] ? ram_a_q : '0;
      if (fwd_en_ff && (fwd_addr_ff == s1_ff.src_reg_a)) begin
         opa = fwd_data_ff;
      end
      if (s1_ff.src_reg_a == REG_ZERO) begin
         opa = '0;
      end
      opb = reg_valid_ff[s1_ff.src_reg_b] ? ram_b_q : '0;
      if (fwd_en_ff && (fwd_addr_ff == s1_ff.src_reg_b)) begin
         opb = fwd_data_ff;
      end
      if (s1_ff.src_reg_b == REG_ZERO) begin
         opb = '0;
      end
   end

   // Run bounds
   always_comb begin
      eff_len = (LEN_W'(program_length_ff) < DEPTH_LEN) ? LEN_W'(program_length_ff) : DEPTH_LEN;
      pc_past_end = LEN_W'(pc_ff) >= eff_len;
      step_over   = ({1'b0, step_ff} + (STEP_W + 1)'(1)) > {1'b0, step_limit_ff};
   end

   // Execute
   always_comb begin
      next_pc_in = pc_ff + PC_W'(1);
      status_in  = ST_RUNNING;
      kind_in    = PRINT_NONE;
      pval_in    = '0;
      fline_in   = '0;
      wr_req     = 1'b0;
      wr_data    = '0;
      stop_set   = 1'b0;
      pc_load    = 1'b0;
      step_inc   = 1'b0;
      if (stopped_ff) begin
         status_in  = ST_STOPPED;
         next_pc_in = pc_ff;
      end else if (pc_past_end) begin
         status_in  = ST_HALTED;
         next_pc_in = pc_ff;
         stop_set   = 1'b1;
      end else if (step_over) begin
         status_in  = ST_STEP_LIMIT;
         next_pc_in = pc_ff;
         stop_set   = 1'b1;
      end else begin
         step_inc = 1'b1;
         unique case (op_type'(s1_ff.mode))
            OP_LI: begin
               wr_req  = 1'b1;
               wr_data = s1_ff.immediate;
            end
            OP_MV: begin
               wr_req  = 1'b1;
               wr_data = opa;
            end
            OP_ADDI: begin
               wr_req  = 1'b1;
               wr_data = opa + s1_ff.immediate;
            end
            OP_ADD: begin
               wr_req  = 1'b1;
               wr_data = opa + opb;
            end
            OP_SUB: begin
               wr_req  = 1'b1;
               wr_data = opa - opb;
            end
            OP_LUI: begin
               wr_req  = 1'b1;
               wr_data = s1_ff.immediate << LUI_SHIFT;
            end
            OP_J: begin
               next_pc_in = s1_ff.jump_target;
            end
            OP_BEQ: begin
               if (opa == opb) begin
                  next_pc_in = s1_ff.jump_target;
               end
            end
            OP_BNE: begin
               if (opa != opb) begin
                  next_pc_in = s1_ff.jump_target;
               end
            end
            OP_ECALL: begin
               if (a7_ff == SYS_PRINT_DEC) begin
                  kind_in = PRINT_DEC;
                  pval_in = a0_ff;
               end else if (a7_ff == SYS_PRINT_HEX) begin
                  kind_in = PRINT_HEX;
                  pval_in = a0_ff;
               end else if (a7_ff == SYS_EXIT) begin
                  status_in = ST_HALTED;
               end else begin
                  status_in = ST_BAD_ECALL;
               end
            end
            OP_NOP: begin
            end
            default: begin
               status_in = ST_BAD_OPCODE;
               fline_in  = s1_ff.line_number;
            end
         endcase
         if (status_in != ST_RUNNING) begin
            // Halt or fault: hold the pc
            next_pc_in = pc_ff;
            stop_set   = 1'b1;
         end else begin
            pc_load = 1'b1;
            if (LEN_W'(next_pc_in) >= eff_len) begin
               status_in = ST_HALTED;
               stop_set  = 1'b1;
            end
         end
      end
      wr_en = advance && wr_req && (s1_ff.dest_reg != REG_ZERO);

      rsp_in.next_pc     = next_pc_in;
      rsp_in.status      = status_in;
      rsp_in.print_kind  = kind_in;
      rsp_in.print_value = pval_in;
      rsp_in.fault_line  = fline_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff     <= STEP_LIMIT_RESET;
         program_length_ff <= '0;
         pc_ff             <= '0;
         step_ff           <= '0;
         stopped_ff        <= 1'b0;
         reg_valid_ff      <= '0;
         a0_ff             <= '0;
         a7_ff             <= '0;
         fwd_en_ff         <= 1'b0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_STEP_LIMIT:     step_limit_ff     <= csr_wdata;
               CSR_PROGRAM_LENGTH: program_length_ff <= csr_wdata[LEN_CFG_W-1:0];
               default: begin
               end
            endcase
         end

         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (advance) begin
            if (pc_load) begin
               pc_ff <= next_pc_in;
            end
            if (step_inc) begin
               step_ff <= step_ff + STEP_W'(1);
            end
            if (stop_set) begin
               stopped_ff <= 1'b1;
            end
         end

         if (wr_en) begin
            reg_valid_ff[s1_ff.dest_reg] <= 1'b1;
            fwd_en_ff                    <= 1'b1;
            if (s1_ff.dest_reg == REG_A0) begin
               a0_ff <= wr_data;
            end
            if (s1_ff.dest_reg == REG_A7) begin
               a7_ff <= wr_data;
            end
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_if.payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_ff.dest_reg;
         fwd_data_ff <= wr_data;
      end
   end

endmodule

FILE: design/mre_ram.sv
module mre_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mre_checker.sv
module mre_checker
   import mre_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Input backs up only behind a stalled result
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input not ready without output stall");

   // Fault line only with a bad opcode
   a_fault_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.fault_line != '0) |->
         rsp_payload.status == ST_BAD_OPCODE)
      else $error("fault line without bad opcode");

   // Print requests only from an instruction that executed normally
   a_print_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.print_kind != PRINT_NONE) |->
         (rsp_payload.status == ST_RUNNING) || (rsp_payload.status == ST_HALTED))
      else $error("print request with fault status");

endmodule

bind mini_rv32_integer_executor mre_checker u_mre_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
